/* hdl/qrs_pkg.sv */
// ----------------------------------------------------------------------------
// qrs_pkg
// Types, widths and constants shared by the quadratic root solver modules.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int COEF_W    = 16;                      // coefficient width
    localparam int FRAC_BITS = 8;                       // fraction bits
    localparam int PROD_W    = 2 * COEF_W;              // product width
    localparam int DISC_W    = 2 * COEF_W + 3;          // signed discriminant
    localparam int SQ_W      = COEF_W + 1;              // root of discriminant
    localparam int SQ_XW     = 2 * SQ_W;                // radicand shift register
    localparam int NUM_W     = COEF_W + 3;              // signed numerator
    localparam int MAG_W     = COEF_W + 2;              // numerator magnitude
    localparam int DV_DW     = MAG_W + FRAC_BITS;       // dividend and quotient
    localparam int DV_RW     = COEF_W + 1;              // divisor and remainder
    localparam int LATENCY   = 2 + SQ_W + 1 + DV_DW + 1;

    typedef enum logic [1:0] {
        ST_REAL     = 2'd0,
        ST_NEG_DISC = 2'd1,
        ST_A_ZERO   = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic signed [COEF_W-1:0] coef_c;
    } t_coef;

    typedef struct packed {
        logic signed [COEF_W-1:0] root_minus;
        logic signed [COEF_W-1:0] root_plus;
        t_status                  solve_status;
        logic                     saturated;
    } t_result;

    // data moving along the square root row
    typedef struct packed {
        logic [SQ_XW-1:0]         x;
        logic [SQ_W:0]            rem;
        logic [SQ_W-1:0]          root;
        t_status                  status;
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
    } t_sq_bus;

    // data moving along a divider row
    typedef struct packed {
        logic [DV_DW-1:0] dd;
        logic [DV_RW-1:0] rem;
        logic [DV_RW-1:0] divisor;
        logic             neg;
        t_status          status;
    } t_dv_bus;

endpackage

/* hdl/qrs_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// qrs_sqrt_cell
// One digit of a pipelined integer square root: resolves one root bit.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell
    import qrs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_sq_bus i_bus,
    output logic    o_valid,
    output t_sq_bus o_bus
);

    logic    r_valid;
    t_sq_bus r_bus;
    t_sq_bus n_bus;

    logic [SQ_W+2:0] rem_sh;
    logic [SQ_W+3:0] trial;

    always_comb begin
        rem_sh = {i_bus.rem, i_bus.x[SQ_XW-1:SQ_XW-2]};
        trial  = {1'b0, rem_sh} - {2'b00, i_bus.root, 2'b01};
        n_bus  = i_bus;
        n_bus.x = {i_bus.x[SQ_XW-3:0], 2'b00};
        if (!trial[SQ_W+3]) begin
            n_bus.rem  = trial[SQ_W:0];
            n_bus.root = {i_bus.root[SQ_W-2:0], 1'b1};
        end else begin
            n_bus.rem  = rem_sh[SQ_W:0];
            n_bus.root = {i_bus.root[SQ_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_bus <= n_bus;
    end

    assign o_valid = r_valid;
    assign o_bus   = r_bus;

endmodule

/* hdl/qrs_div_cell.sv */
// ----------------------------------------------------------------------------
// qrs_div_cell
// One step of a pipelined restoring divider: resolves one quotient bit.
// ----------------------------------------------------------------------------
module qrs_div_cell
    import qrs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_dv_bus i_bus,
    output logic    o_valid,
    output t_dv_bus o_bus
);

    logic    r_valid;
    t_dv_bus r_bus;
    t_dv_bus n_bus;

    logic [DV_RW:0]   rem_sh;
    logic [DV_RW+1:0] diff;

    always_comb begin
        rem_sh = {i_bus.rem, i_bus.dd[DV_DW-1]};
        diff   = {1'b0, rem_sh} - {2'b00, i_bus.divisor};
        n_bus  = i_bus;
        // quotient bits shift in behind the dividend bits
        n_bus.dd  = {i_bus.dd[DV_DW-2:0], ~diff[DV_RW+1]};
        n_bus.rem = diff[DV_RW+1] ? rem_sh[DV_RW-1:0] : diff[DV_RW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_bus <= n_bus;
    end

    assign o_valid = r_valid;
    assign o_bus   = r_bus;

endmodule

/* hdl/quadratic_root_solver.sv */
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c in signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Pipeline: the product and discriminant stages, the square root row, the
//   numerator stage, the divider rows and the output stage; Q8.8 coefficients.
// Throughput: one item per cycle; busy never rises and the receiver cannot
//   stall, so items leave in the order in which they entered.
// Reset: synchronous, active low; clears every valid bit, payload is not reset.
// ----------------------------------------------------------------------------
module quadratic_root_solver
    import qrs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_coef   i_cmd,
    output logic    o_done,
    output t_result o_res
);

    // ------------------------------------------------------------------
    // Stage 1: the two products b*b and a*c
    // ------------------------------------------------------------------
    logic                     accept;
    logic                     r_s1_valid;
    logic signed [PROD_W-1:0] r_s1_bb;
    logic signed [PROD_W-1:0] r_s1_ac;
    logic signed [COEF_W-1:0] r_s1_a;
    logic signed [COEF_W-1:0] r_s1_b;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
        r_s1_bb <= i_cmd.coef_b * i_cmd.coef_b;
        r_s1_ac <= i_cmd.coef_a * i_cmd.coef_c;
        r_s1_a  <= i_cmd.coef_a;
        r_s1_b  <= i_cmd.coef_b;
    end

    // ------------------------------------------------------------------
    // Stage 2: exact discriminant and the special cases
    // ------------------------------------------------------------------
    logic signed [DISC_W-1:0] disc;
    t_sq_bus                  n_sq_head;
    t_sq_bus                  r_sq_head;
    logic                     r_sq_head_valid;

    always_comb begin
        disc = {{3{r_s1_bb[PROD_W-1]}}, r_s1_bb} - {r_s1_ac[PROD_W-1], r_s1_ac, 2'b00};
        n_sq_head.x    = {1'b0, disc[DISC_W-3:0]};
        n_sq_head.rem  = '0;
        n_sq_head.root = '0;
        n_sq_head.a    = r_s1_a;
        n_sq_head.b    = r_s1_b;
        // zero a wins over a negative discriminant
        if (r_s1_a == '0) begin
            n_sq_head.status = ST_A_ZERO;
        end else if (disc[DISC_W-1]) begin
            n_sq_head.status = ST_NEG_DISC;
        end else begin
            n_sq_head.status = ST_REAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_head_valid <= 1'b0;
        end else begin
            r_sq_head_valid <= r_s1_valid;
        end
        r_sq_head <= n_sq_head;
    end

    // ------------------------------------------------------------------
    // Square root row: one cell for each root bit, most significant first
    // ------------------------------------------------------------------
    t_sq_bus sq_bus   [SQ_W+1];
    logic    sq_valid [SQ_W+1];

    assign sq_bus[0]   = r_sq_head;
    assign sq_valid[0] = r_sq_head_valid;

    for (genvar k = 0; k < SQ_W; k++) begin : g_sqrt
        qrs_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (sq_valid[k]),
            .i_bus   (sq_bus[k]),
            .o_valid (sq_valid[k+1]),
            .o_bus   (sq_bus[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Numerator stage: -b -/+ sqrt(D) as sign and magnitude, divisor 2|a|
    // ------------------------------------------------------------------
    t_sq_bus                 sq_tail;
    logic signed [NUM_W-1:0] neg_b;
    logic signed [NUM_W-1:0] num_m;
    logic signed [NUM_W-1:0] num_p;
    logic [NUM_W-1:0]        mag_m;
    logic [NUM_W-1:0]        mag_p;
    logic [COEF_W-1:0]       a_mag;
    t_dv_bus                 n_dm_head;
    t_dv_bus                 n_dp_head;
    t_dv_bus                 r_dm_head;
    t_dv_bus                 r_dp_head;
    logic                    r_dv_head_valid;

    always_comb begin
        sq_tail = sq_bus[SQ_W];
        neg_b   = -{{3{sq_tail.b[COEF_W-1]}}, sq_tail.b};
        num_m   = neg_b - $signed({2'b00, sq_tail.root});
        num_p   = neg_b + $signed({2'b00, sq_tail.root});
        mag_m   = num_m[NUM_W-1] ? -num_m : num_m;
        mag_p   = num_p[NUM_W-1] ? -num_p : num_p;
        a_mag   = sq_tail.a[COEF_W-1] ? -sq_tail.a : sq_tail.a;

        n_dm_head.dd      = {mag_m[MAG_W-1:0], {FRAC_BITS{1'b0}}};
        n_dm_head.rem     = '0;
        n_dm_head.divisor = {a_mag, 1'b0};
        n_dm_head.neg     = num_m[NUM_W-1] ^ sq_tail.a[COEF_W-1];
        n_dm_head.status  = sq_tail.status;

        n_dp_head         = n_dm_head;
        n_dp_head.dd      = {mag_p[MAG_W-1:0], {FRAC_BITS{1'b0}}};
        n_dp_head.neg     = num_p[NUM_W-1] ^ sq_tail.a[COEF_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_head_valid <= 1'b0;
        end else begin
            r_dv_head_valid <= sq_valid[SQ_W];
        end
        r_dm_head <= n_dm_head;
        r_dp_head <= n_dp_head;
    end

    // ------------------------------------------------------------------
    // Divider rows: one cell for each quotient bit, one row for each root
    // ------------------------------------------------------------------
    t_dv_bus dm_bus   [DV_DW+1];
    t_dv_bus dp_bus   [DV_DW+1];
    logic    dm_valid [DV_DW+1];
    logic    dp_valid [DV_DW+1];

    assign dm_bus[0]   = r_dm_head;
    assign dp_bus[0]   = r_dp_head;
    assign dm_valid[0] = r_dv_head_valid;
    assign dp_valid[0] = r_dv_head_valid;

    for (genvar k = 0; k < DV_DW; k++) begin : g_div
        qrs_div_cell u_minus (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (dm_valid[k]),
            .i_bus   (dm_bus[k]),
            .o_valid (dm_valid[k+1]),
            .o_bus   (dm_bus[k+1])
        );
        qrs_div_cell u_plus (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (dp_valid[k]),
            .i_bus   (dp_bus[k]),
            .o_valid (dp_valid[k+1]),
            .o_bus   (dp_bus[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Output stage: apply the sign, clamp to the coefficient range
    // ------------------------------------------------------------------
    localparam logic [DV_DW-1:0] QPOS_MAX = DV_DW'((64'd1 << (COEF_W - 1)) - 64'd1);
    localparam logic [DV_DW-1:0] QNEG_MAX = DV_DW'(64'd1 << (COEF_W - 1));

    t_dv_bus           dm_tail;
    t_dv_bus           dp_tail;
    logic [COEF_W-1:0] rm_val;
    logic [COEF_W-1:0] rp_val;
    logic              rm_sat;
    logic              rp_sat;
    logic              r_done;
    t_result           r_res;
    t_result           n_res;

    always_comb begin
        dm_tail = dm_bus[DV_DW];
        dp_tail = dp_bus[DV_DW];

        // minus root
        rm_sat = 1'b0;
        if (!dm_tail.neg) begin
            if (dm_tail.dd > QPOS_MAX) begin
                rm_sat = 1'b1;
                rm_val = QPOS_MAX[COEF_W-1:0];
            end else begin
                rm_val = dm_tail.dd[COEF_W-1:0];
            end
        end else begin
            if (dm_tail.dd > QNEG_MAX) begin
                rm_sat = 1'b1;
                rm_val = -QNEG_MAX[COEF_W-1:0];
            end else begin
                rm_val = -dm_tail.dd[COEF_W-1:0];
            end
        end

        // plus root
        rp_sat = 1'b0;
        if (!dp_tail.neg) begin
            if (dp_tail.dd > QPOS_MAX) begin
                rp_sat = 1'b1;
                rp_val = QPOS_MAX[COEF_W-1:0];
            end else begin
                rp_val = dp_tail.dd[COEF_W-1:0];
            end
        end else begin
            if (dp_tail.dd > QNEG_MAX) begin
                rp_sat = 1'b1;
                rp_val = -QNEG_MAX[COEF_W-1:0];
            end else begin
                rp_val = -dp_tail.dd[COEF_W-1:0];
            end
        end

        // drop the roots unless both are real
        n_res.solve_status = dm_tail.status;
        if (dm_tail.status == ST_REAL) begin
            n_res.root_minus = rm_val;
            n_res.root_plus  = rp_val;
            n_res.saturated  = rm_sat | rp_sat;
        end else begin
            n_res.root_minus = '0;
            n_res.root_plus  = '0;
            n_res.saturated  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= dm_valid[DV_DW];
        end
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // every accepted item leaves after exactly the pipeline depth
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_done)
        else $error("item did not leave after the pipeline depth");

    // no result without an item accepted that far back
    a_no_ghost : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, LATENCY))
        else $error("result without an accepted item");

    // special cases carry zero roots and no clamp
    a_special_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.solve_status != ST_REAL) |->
        (o_res.root_minus == '0 && o_res.root_plus == '0 && !o_res.saturated))
        else $error("special case carries roots");

endmodule

/* bench/quadratic_root_solver_chk.sv */
// ----------------------------------------------------------------------------
// quadratic_root_solver_chk
// Watches the coefficient and result channels, predicts each result and
// compares it field by field with what the solver gives.
// ----------------------------------------------------------------------------
module quadratic_root_solver_chk
    import qrs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_busy,
    input  t_coef   i_cmd,
    input  logic    i_done,
    input  t_result i_res,
    output int      o_errors,
    output int      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t_result roots_due[$];

    // integer square root, floor
    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // scale num by 2^FRAC_BITS, divide by 2a toward zero, clamp
    function automatic logic [COEF_W-1:0] scaled_quotient(longint num, longint a,
                                                           inout logic clamped);
        logic neg;
        longint unsigned nm;
        longint unsigned am;
        longint unsigned q;
        neg = (num < 0) != (a < 0);
        nm  = (num < 0) ? -num : num;
        am  = (a < 0) ? -a : a;
        q   = (nm << FRAC_BITS) / (am * 2);
        if (q == 0) return '0;
        if (!neg) begin
            if (q > (64'd1 << (COEF_W-1)) - 1) begin
                clamped = 1'b1;
                q = (64'd1 << (COEF_W-1)) - 1;
            end
            return q[COEF_W-1:0];
        end
        if (q > (64'd1 << (COEF_W-1))) begin
            clamped = 1'b1;
            q = 64'd1 << (COEF_W-1);
        end
        q = -q;
        return q[COEF_W-1:0];
    endfunction

    function automatic t_result solve_roots(t_coef c);
        t_result r;
        longint a, b, k, disc, s;
        logic clamped;
        a = c.coef_a;
        b = c.coef_b;
        k = c.coef_c;
        r = '0;
        clamped = 1'b0;
        if (a == 0) begin
            r.solve_status = ST_A_ZERO;
            return r;
        end
        disc = b * b - 4 * a * k;
        if (disc < 0) begin
            r.solve_status = ST_NEG_DISC;
            return r;
        end
        s = floor_sqrt(disc);
        r.root_minus   = scaled_quotient(-b - s, a, clamped);
        r.root_plus    = scaled_quotient(-b + s, a, clamped);
        r.solve_status = ST_REAL;
        r.saturated    = clamped;
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t: mismatch: %s", $realtime, what);
        o_errors++;
    endtask

    initial o_errors = 0;
    assign o_pending = roots_due.size();

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && i_start && !i_busy) roots_due.push_back(solve_roots(i_cmd));
        if (i_rst_n && i_done) begin
            if (roots_due.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                want = roots_due.pop_front();
                if (i_res.root_minus !== want.root_minus)
                    report_mismatch($sformatf("root_minus %h want %h",
                                    i_res.root_minus, want.root_minus));
                if (i_res.root_plus !== want.root_plus)
                    report_mismatch($sformatf("root_plus %h want %h",
                                    i_res.root_plus, want.root_plus));
                if (i_res.solve_status !== want.solve_status)
                    report_mismatch($sformatf("solve_status %0d want %0d",
                                    i_res.solve_status, want.solve_status));
                if (i_res.saturated !== want.saturated)
                    report_mismatch($sformatf("saturated %b want %b",
                                    i_res.saturated, want.saturated));
            end
        end
    end
endmodule

/* bench/quadratic_root_solver_tb.sv */
// ----------------------------------------------------------------------------
// quadratic_root_solver_tb
// Drives directed then random coefficient sets into the solver, with bursts
// of idle cycles, and gives the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module quadratic_root_solver_tb;
    import qrs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM  = 1700;
    localparam int CYC_LIMIT = 200000;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    t_coef   cmd;
    logic    done;
    t_result res;
    int      errors;
    int      pending;
    int      cycles;

    quadratic_root_solver dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (cmd),
        .o_done  (done),
        .o_res   (res)
    );

    quadratic_root_solver_chk chk (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_start   (start),
        .i_busy    (busy),
        .i_cmd     (cmd),
        .i_done    (done),
        .i_res     (res),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Stop a hung run: count cycles and give up well past the slowest pass.
    initial cycles = 0;
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYC_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Present one coefficient set and hold it until the solver takes it.
    task automatic send_coefs(logic [15:0] a, logic [15:0] b, logic [15:0] c);
        start <= 1'b1;
        cmd   <= '{coef_a: a, coef_b: b, coef_c: c};
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    task automatic idle_burst();
        start <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
    endtask

    // Pick a value leaning on the edges of the Q8.8 range and on small ones.
    function automatic logic [15:0] pick_coef();
        case ($urandom_range(0, 5))
            0: return 16'(16'h8000 + $urandom_range(0, 3));
            1: return 16'(16'h7fff - $urandom_range(0, 3));
            2: return $urandom_range(0, 1) ? 16'($urandom_range(0, 4)) : -16'($urandom_range(0, 4));
            3: return 16'($signed(8'($urandom())));
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin
        logic [15:0] a, b, c;
        rst_n = 1'b0;
        start = 1'b0;
        cmd   = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: zero a, negative discriminant, a zero discriminant,
        // saturating roots both ways, and the field extremes.
        send_coefs(16'h0000, 16'h0100, 16'h0100);
        send_coefs(16'h0000, 16'h0000, 16'hff00);
        send_coefs(16'h0100, 16'h0000, 16'h0100);
        send_coefs(16'h0100, 16'hfe00, 16'h0100);
        send_coefs(16'h0100, 16'h0000, 16'hfc00);
        send_coefs(16'h0001, 16'h7fff, 16'h0000);
        send_coefs(16'h0001, 16'h8000, 16'h0000);
        send_coefs(16'hffff, 16'h7fff, 16'h7fff);
        send_coefs(16'h8000, 16'h8000, 16'h7fff);
        send_coefs(16'h7fff, 16'h7fff, 16'h8000);
        send_coefs(16'h8000, 16'h0000, 16'h7fff);
        send_coefs(16'h7fff, 16'h0000, 16'h8000);
        send_coefs(16'hffff, 16'hffff, 16'hffff);
        send_coefs(16'h0001, 16'h0001, 16'h0000);
        send_coefs(16'hff00, 16'h0300, 16'hfe00);
        send_coefs(16'h0200, 16'h0000, 16'h0000);
        idle_burst();

        // Random, with idle bursts except in the closing stretch.
        for (int i = 0; i < N_RANDOM; i++) begin
            a = pick_coef();
            b = pick_coef();
            c = pick_coef();
            // one time in three, flip c if a and c share a sign: -4ac >= 0 unless c is 16'h8000
            if ($urandom_range(0, 2) == 0 && a != 0 && ($signed(a) < 0) == ($signed(c) < 0))
                c = -c;
            send_coefs(a, b, c);
            if (i < N_RANDOM - 200 && $urandom_range(0, 7) == 0) idle_burst();
        end
        start <= 1'b0;

        // Drain, then allow the pipeline depth to flush any stray strobe.
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
